FILE: rtl/core/lllb_pkg.sv
// ----------------------------------------------------------------------------
// lllb_pkg
// Shared types, constants and helpers for the least-loaded link balancer.
// ----------------------------------------------------------------------------
package lllb_pkg;

   // Table geometry
   localparam int MAX_ENTRIES   = 4;
   localparam int LINK_ID_WIDTH = 4;
   localparam int IDX_W         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);

   // Load compare width: queued*8 (35 bits) against rate/8, signed
   localparam int LOAD_W        = 37;

   localparam logic [2:0]  MAX_LINKS_RESET = 3'd4;
   localparam logic [31:0] QUEUE_MAX       = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_TRANSMIT = 3'd0,
      OP_TICK     = 3'd1,
      OP_ENSLAVE  = 3'd2,
      OP_RELEASE  = 3'd3,
      OP_SET_RATE = 3'd4,
      OP_QUERY    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DROPPED = 2'd1,
      ST_INVALID = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY
   } state_type;

   typedef logic [LINK_ID_WIDTH-1:0] link_id_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  link_id;
      logic [31:0] rate_bps;
      logic [15:0] packet_len;
      logic [15:0] link_up_mask;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  selected_link;
      logic [31:0] link_rate;
      logic        removed_valid;
      logic [3:0]  removed_link;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic apply;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
   } ctl_stat_type;

   // Identities of sixteen and above have no up bit and count as down
   function automatic logic link_is_up(input link_id_type id, input logic [15:0] mask);
      logic [31:0] wide;
      wide = 32'(id);
      return (wide < 32'd16) && mask[wide[3:0]];
   endfunction

endpackage

FILE: rtl/core/least_load_link_balancer.sv
// ----------------------------------------------------------------------------
// least_load_link_balancer
// Ordered link table with least-loaded transmit selection, drain and upkeep.
// ----------------------------------------------------------------------------
// An accepted beat (start high, busy low) holds busy through the scan, in which
// the table of links is scanned one entry per cycle, and through the apply
// state that updates it. The result appears on rsp_data with rsp_valid for
// exactly one cycle, the same cycle in which busy falls, and the next beat
// may be accepted in that same cycle. The result is not held: sample it on the
// strobe. Write max_links through csr_write_en only while the block is idle.
module least_load_link_balancer
   import lllb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_write_en,
   input  logic [2:0] csr_write_data
);

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // Sequencer
   lllb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Table and result path
   lllb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data)
   );

endmodule

FILE: rtl/core/lllb_ctrl.sv
// ----------------------------------------------------------------------------
// lllb_ctrl
// Sequencer: accept a command, step the table scan, then apply and respond.
// ----------------------------------------------------------------------------
module lllb_ctrl
   import lllb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_load_to_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_SCAN))
      else $error("accepted beat did not start a scan");

   a_apply_once: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> !cmd.apply)
      else $error("apply lasted more than one cycle");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.step && !cmd.apply)
      else $error("load overlapped scan or apply");
`endif

endmodule

FILE: rtl/core/lllb_datapath.sv
// ----------------------------------------------------------------------------
// lllb_datapath
// Link table, scan trackers, table update and result register.
// ----------------------------------------------------------------------------
module lllb_datapath
   import lllb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_write_data,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   // Table
   link_id_type       link_ff   [MAX_ENTRIES];
   link_id_type       link_in   [MAX_ENTRIES];
   logic [31:0]       rate_ff   [MAX_ENTRIES];
   logic [31:0]       rate_in   [MAX_ENTRIES];
   logic [31:0]       queued_ff [MAX_ENTRIES];
   logic [31:0]       queued_in [MAX_ENTRIES];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        max_links_ff;

   // Captured request and scan trackers
   req_type           req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              best_found_ff, best_found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [LOAD_W-1:0] min_load_ff, min_load_in;
   link_id_type       best_link_ff, best_link_in;
   logic [31:0]       best_queued_ff, best_queued_in;
   logic              corpse_found_ff, corpse_found_in;
   logic [IDX_W-1:0]  corpse_idx_ff, corpse_idx_in;
   link_id_type       corpse_link_ff, corpse_link_in;
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [31:0]       match_rate_ff, match_rate_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Current scan entry
   link_id_type       cur_link;
   logic [31:0]       cur_rate;
   logic [31:0]       cur_queued;
   logic              cur_live;
   logic              cur_up;
   logic [31:0]       cur_drain;
   logic [LOAD_W-1:0] cur_load;
   link_id_type       req_id;
   logic              table_full;
   logic [32:0]       q_sum;
   logic [31:0]       q_sat;

   assign cur_link   = link_ff[idx_ff];
   assign cur_rate   = rate_ff[idx_ff];
   assign cur_queued = queued_ff[idx_ff];
   assign cur_live   = (CNT_W'(idx_ff) < count_ff);
   assign cur_up     = link_is_up(cur_link, req_ff.link_up_mask);
   assign cur_drain  = {3'b000, cur_rate[31:3]};
   assign cur_load   = {2'b00, cur_queued, 3'b000} - {8'h00, cur_rate[31:3]};
   assign req_id     = LINK_ID_WIDTH'(req_ff.link_id);

   // Full when count reaches the lesser of max_links and the table depth
   assign table_full = (32'(count_ff) >= 32'(max_links_ff)) ||
                       (32'(count_ff) >= 32'(MAX_ENTRIES));

   // Saturating grow of the chosen link's queue
   assign q_sum = {1'b0, best_queued_ff} + 33'(req_ff.packet_len);
   assign q_sat = q_sum[32] ? QUEUE_MAX : q_sum[31:0];

   // Scan ends on the last live entry, or at once on an empty table
   assign stat.scan_done = (CNT_W'(idx_ff) + CNT_W'(1) >= count_ff);

   // Next-state logic
   always_comb begin
      logic [31:0]      q_mod [MAX_ENTRIES];
      logic             do_drop;
      logic [IDX_W-1:0] drop_pos;
      logic             do_insert;

      link_in         = link_ff;
      rate_in         = rate_ff;
      queued_in       = queued_ff;
      count_in        = count_ff;
      req_in          = req_ff;
      idx_in          = idx_ff;
      best_found_in   = best_found_ff;
      best_idx_in     = best_idx_ff;
      min_load_in     = min_load_ff;
      best_link_in    = best_link_ff;
      best_queued_in  = best_queued_ff;
      corpse_found_in = corpse_found_ff;
      corpse_idx_in   = corpse_idx_ff;
      corpse_link_in  = corpse_link_ff;
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      match_rate_in   = match_rate_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = 1'b0;
      q_mod           = queued_ff;
      do_drop         = 1'b0;
      drop_pos        = '0;
      do_insert       = 1'b0;

      priority if (cmd.load) begin
         // Capture the beat and clear the trackers
         req_in          = req_data;
         idx_in          = '0;
         best_found_in   = 1'b0;
         corpse_found_in = 1'b0;
         match_found_in  = 1'b0;
      end else if (cmd.step) begin
         // Examine one entry
         if (cur_live) begin
            if (req_ff.opcode == OP_TRANSMIT || req_ff.opcode == OP_TICK) begin
               if (cur_up) begin
                  if (req_ff.opcode == OP_TRANSMIT) begin
                     if (!best_found_ff || ($signed(cur_load) < $signed(min_load_ff))) begin
                        best_found_in  = 1'b1;
                        best_idx_in    = idx_ff;
                        min_load_in    = cur_load;
                        best_link_in   = cur_link;
                        best_queued_in = cur_queued;
                     end
                  end else begin
                     queued_in[idx_ff] = (cur_queued > cur_drain) ?
                                         (cur_queued - cur_drain) : 32'd0;
                  end
               end else begin
                  corpse_found_in = 1'b1;
                  corpse_idx_in   = idx_ff;
                  corpse_link_in  = cur_link;
               end
            end else if (!match_found_ff && cur_link == req_id) begin
               match_found_in = 1'b1;
               match_idx_in   = idx_ff;
               match_rate_in  = cur_rate;
            end
         end
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.apply) begin
         // Apply the command and build the result
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         rsp_in.status = ST_OK;
         unique case (req_ff.opcode)
            OP_TRANSMIT, OP_TICK: begin
               if (req_ff.opcode == OP_TRANSMIT) begin
                  if (best_found_ff) begin
                     q_mod[best_idx_ff]   = q_sat;
                     rsp_in.selected_link = 4'(best_link_ff);
                  end else begin
                     rsp_in.status = ST_DROPPED;
                  end
               end
               if (corpse_found_ff) begin
                  do_drop              = 1'b1;
                  drop_pos             = corpse_idx_ff;
                  rsp_in.removed_valid = 1'b1;
                  rsp_in.removed_link  = 4'(corpse_link_ff);
               end
            end
            OP_ENSLAVE: begin
               if (match_found_ff) begin
                  rsp_in.status = ST_INVALID;
               end else if (table_full) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  do_insert        = 1'b1;
                  rsp_in.link_rate = req_ff.rate_bps;
               end
            end
            OP_RELEASE, OP_SET_RATE, OP_QUERY: begin
               if (!match_found_ff) begin
                  rsp_in.status = ST_INVALID;
               end else if (req_ff.opcode == OP_RELEASE) begin
                  rsp_in.link_rate = match_rate_ff;
                  do_drop          = 1'b1;
                  drop_pos         = match_idx_ff;
               end else if (req_ff.opcode == OP_SET_RATE) begin
                  rate_in[match_idx_ff] = req_ff.rate_bps;
                  rsp_in.link_rate      = req_ff.rate_bps;
               end else begin
                  rsp_in.link_rate = match_rate_ff;
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase

         queued_in = q_mod;

         // Insert at the head, pushing the rest down
         if (do_insert) begin
            for (int i = MAX_ENTRIES - 1; i > 0; i--) begin
               link_in[i]   = link_ff[i-1];
               rate_in[i]   = rate_ff[i-1];
               queued_in[i] = queued_ff[i-1];
            end
            link_in[0]   = req_id;
            rate_in[0]   = req_ff.rate_bps;
            queued_in[0] = 32'd0;
            count_in     = count_ff + CNT_W'(1);
         end

         // Remove one entry, closing the gap
         if (do_drop) begin
            for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
               if ((i >= int'(drop_pos)) && (i + 1 < int'(count_ff))) begin
                  link_in[i]   = link_ff[i+1];
                  rate_in[i]   = rate_ff[i+1];
                  queued_in[i] = q_mod[i+1];
               end
            end
            count_in = count_ff - CNT_W'(1);
         end
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         max_links_ff <= MAX_LINKS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            max_links_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      link_ff         <= link_in;
      rate_ff         <= rate_in;
      queued_ff       <= queued_in;
      req_ff          <= req_in;
      idx_ff          <= idx_in;
      best_found_ff   <= best_found_in;
      best_idx_ff     <= best_idx_in;
      min_load_ff     <= min_load_in;
      best_link_ff    <= best_link_in;
      best_queued_ff  <= best_queued_in;
      corpse_found_ff <= corpse_found_in;
      corpse_idx_ff   <= corpse_idx_in;
      corpse_link_ff  <= corpse_link_in;
      match_found_ff  <= match_found_in;
      match_idx_ff    <= match_idx_in;
      match_rate_ff   <= match_rate_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FULL) |-> (count_ff == $past(count_ff)))
      else $error("table changed size on a full enslave");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.removed_valid) |->
         (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("removal did not shrink the table");

   a_enslave_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && req_ff.opcode == OP_ENSLAVE && rsp_ff.status == ST_OK) |->
         (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("enslave did not grow the table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> (32'(count_ff) <= 32'(MAX_ENTRIES)))
      else $error("link count beyond table depth");
`endif

endmodule

FILE: sim/least_load_link_balancer_tb.sv
// ----------------------------------------------------------------------------
// least_load_link_balancer_tb
// Self-checking bench for the least-loaded link balancer. A local table model
// predicts each response as its command beat is accepted; responses are
// compared field by field, in order, as they are strobed out. Directed tests
// cover the empty table, fill and duplicate checks, tie-breaking, upkeep of
// down links, the max_links limit and queued-count growth, followed by
// random command traffic over every max_links setting.
// ----------------------------------------------------------------------------
module least_load_link_balancer_tb;
   import lllb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WATCHDOG_LIMIT = 1000;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          GROW_BEATS     = 16;
   localparam int          RANDOM_BEATS   = 125;
   localparam logic [2:0]  OP_SPARE_LO    = 3'd6;
   localparam logic [2:0]  OP_SPARE_HI    = 3'd7;
   localparam logic [15:0] ALL_UP         = 16'hFFFF;
   localparam logic [63:0] LOAD_BIAS      = 64'h8000_0000_0000_0000;

   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       start          = 1'b0;
   logic       busy;
   req_type    req_data       = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_write_en   = 1'b0;
   logic [2:0] csr_write_data = '0;

   // Link table model
   logic [3:0]  tbl_link   [MAX_ENTRIES];
   logic [31:0] tbl_rate   [MAX_ENTRIES];
   logic [31:0] tbl_queued [MAX_ENTRIES];
   int          tbl_count     = 0;
   int          tbl_max_links = MAX_LINKS_RESET;

   rsp_type link_result_q [$];

   bit idle_enable     = 1'b1;
   int mismatches      = 0;
   int results_checked = 0;
   int beats_sent      = 0;
   int packets_sent    = 0;
   int packets_dropped = 0;
   int links_removed   = 0;
   int full_rejects    = 0;
   int stall_cycles    = 0;

   least_load_link_balancer u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // ----- table model -----

   function automatic int find_link(input logic [3:0] id);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_link[i] == id)
            return i;
      return -1;
   endfunction

   // Close the gap left by a removed entry
   function automatic void remove_entry(input int pos);
      for (int i = pos; i + 1 < tbl_count; i++) begin
         tbl_link[i]   = tbl_link[i + 1];
         tbl_rate[i]   = tbl_rate[i + 1];
         tbl_queued[i] = tbl_queued[i + 1];
      end
      tbl_count--;
   endfunction

   // Apply one command to the table and return the response it produces
   function automatic rsp_type apply_link_command(input req_type beat);
      rsp_type     res;
      int          best;
      int          last_down;
      int          pos;
      int          limit;
      logic [63:0] lowest_load;
      logic [63:0] load;
      logic [31:0] drain;
      logic [32:0] grown;
      res         = '0;
      best        = -1;
      last_down   = -1;
      lowest_load = '1;
      case (beat.opcode)
         OP_TRANSMIT, OP_TICK: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (beat.link_up_mask[tbl_link[i]]) begin
                  if (beat.opcode == OP_TRANSMIT) begin
                     load = LOAD_BIAS - 64'(tbl_rate[i] >> 3) + (64'(tbl_queued[i]) << 3);
                     // strict less: the earlier entry keeps a tie
                     if (load < lowest_load) begin
                        lowest_load = load;
                        best        = i;
                     end
                  end else begin
                     drain         = tbl_rate[i] >> 3;
                     tbl_queued[i] = (tbl_queued[i] > drain) ? tbl_queued[i] - drain : '0;
                  end
               end else begin
                  last_down = i;
               end
            end
            if (beat.opcode == OP_TRANSMIT) begin
               if (best >= 0) begin
                  grown            = 33'(tbl_queued[best]) + 33'(beat.packet_len);
                  tbl_queued[best] = grown[32] ? QUEUE_MAX : grown[31:0];
                  res.selected_link = tbl_link[best];
               end else begin
                  res.status = ST_DROPPED;
               end
            end
            if (last_down >= 0) begin
               res.removed_valid = 1'b1;
               res.removed_link  = tbl_link[last_down];
               remove_entry(last_down);
            end
         end
         OP_ENSLAVE: begin
            limit = (tbl_max_links < MAX_ENTRIES) ? tbl_max_links : MAX_ENTRIES;
            if (find_link(beat.link_id) >= 0) begin
               res.status = ST_INVALID;
            end else if (tbl_count >= limit) begin
               res.status = ST_FULL;
            end else begin
               // insert at the head
               for (int i = tbl_count; i > 0; i--) begin
                  tbl_link[i]   = tbl_link[i - 1];
                  tbl_rate[i]   = tbl_rate[i - 1];
                  tbl_queued[i] = tbl_queued[i - 1];
               end
               tbl_link[0]   = beat.link_id;
               tbl_rate[0]   = beat.rate_bps;
               tbl_queued[0] = '0;
               tbl_count++;
               res.link_rate = beat.rate_bps;
            end
         end
         OP_RELEASE, OP_SET_RATE, OP_QUERY: begin
            pos = find_link(beat.link_id);
            if (pos < 0) begin
               res.status = ST_INVALID;
            end else if (beat.opcode == OP_RELEASE) begin
               res.link_rate = tbl_rate[pos];
               remove_entry(pos);
            end else begin
               if (beat.opcode == OP_SET_RATE)
                  tbl_rate[pos] = beat.rate_bps;
               res.link_rate = tbl_rate[pos];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // ----- stimulus helpers -----

   function automatic req_type make_beat(input logic [2:0] op, input logic [3:0] id,
                                         input logic [31:0] rate, input logic [15:0] len,
                                         input logic [15:0] mask);
      req_type b;
      b.opcode       = op;
      b.link_id      = id;
      b.rate_bps     = rate;
      b.packet_len   = len;
      b.link_up_mask = mask;
      return b;
   endfunction

   // Offer one command beat, hold it until accepted, then record its response
   task automatic send_beat(input req_type beat);
      rsp_type want;
      if (idle_enable && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      want = apply_link_command(beat);
      link_result_q.push_back(want);
      beats_sent++;
      if (beat.opcode == OP_TRANSMIT && want.status == ST_OK)
         packets_sent++;
      if (want.status == ST_DROPPED)
         packets_dropped++;
      if (want.status == ST_FULL)
         full_rejects++;
      if (want.removed_valid)
         links_removed++;
   endtask

   // Drop start and wait for every outstanding response, then let the block settle
   task automatic drain_results();
      start <= 1'b0;
      while (link_result_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_links(input logic [2:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tbl_max_links  = value;
   endtask

   function automatic req_type random_beat();
      req_type b;
      int      pick;
      b    = '0;
      pick = $urandom_range(0, 99);
      if      (pick < 35) b.opcode = OP_TRANSMIT;
      else if (pick < 50) b.opcode = OP_TICK;
      else if (pick < 70) b.opcode = OP_ENSLAVE;
      else if (pick < 78) b.opcode = OP_RELEASE;
      else if (pick < 86) b.opcode = OP_SET_RATE;
      else if (pick < 94) b.opcode = OP_QUERY;
      else if (pick < 97) b.opcode = OP_SPARE_LO;
      else                b.opcode = OP_SPARE_HI;
      // mostly address live links, except enslave which mostly picks fresh ones
      if (tbl_count > 0 && ($urandom_range(0, 3) == 0) == (b.opcode == OP_ENSLAVE))
         b.link_id = tbl_link[$urandom_range(0, tbl_count - 1)];
      else
         b.link_id = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 5))
         0:       b.rate_bps = '0;
         1:       b.rate_bps = '1;
         2:       b.rate_bps = $urandom_range(0, 4096);
         default: b.rate_bps = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0:       b.packet_len = '0;
         1:       b.packet_len = '1;
         default: b.packet_len = 16'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if      (pick < 50) b.link_up_mask = ALL_UP;
      else if (pick < 80) b.link_up_mask = ALL_UP & ~(16'd1 << $urandom_range(0, 15));
      else                b.link_up_mask = 16'($urandom);
      return b;
   endfunction

   // ----- tests -----

   task automatic test_empty_table();
      send_beat(make_beat(OP_TRANSMIT, 4'd0, '0, 16'd100, ALL_UP));
      send_beat(make_beat(OP_TICK, 4'd0, '0, '0, ALL_UP));
      send_beat(make_beat(OP_RELEASE, 4'd3, '0, '0, ALL_UP));
      send_beat(make_beat(OP_SET_RATE, 4'd3, 32'd1000, '0, ALL_UP));
      send_beat(make_beat(OP_SPARE_LO, 4'd3, '1, '1, ALL_UP));
      drain_results();
   endtask

   task automatic test_table_fill();
      send_beat(make_beat(OP_ENSLAVE, 4'd0, '0, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd15, '1, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd15, 32'd5, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd5, 32'd800, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd10, 32'd800, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd7, 32'd800, '0, ALL_UP));
      drain_results();
   endtask

   task automatic test_selection();
      // fastest link wins, then a tie between equal links with one link down
      send_beat(make_beat(OP_TRANSMIT, '0, '0, '1, ALL_UP));
      send_beat(make_beat(OP_TRANSMIT, '0, '0, '0, 16'h7FFF));
      send_beat(make_beat(OP_TICK, '0, '0, '0, ALL_UP));
      // nothing up: drop the packet but still remove the last down link
      send_beat(make_beat(OP_TRANSMIT, '0, '0, 16'd64, 16'h0000));
      drain_results();
   endtask

   task automatic test_rate_update();
      send_beat(make_beat(OP_SET_RATE, 4'd5, '1, '0, ALL_UP));
      send_beat(make_beat(OP_QUERY, 4'd5, '0, '0, ALL_UP));
      send_beat(make_beat(OP_RELEASE, 4'd10, '0, '0, ALL_UP));
      send_beat(make_beat(OP_QUERY, 4'd10, '0, '0, ALL_UP));
      send_beat(make_beat(OP_RELEASE, 4'd5, '0, '0, ALL_UP));
      drain_results();
   endtask

   task automatic test_table_limits();
      write_max_links(3'd0);
      send_beat(make_beat(OP_ENSLAVE, 4'd3, 32'd64, '0, ALL_UP));
      drain_results();
      // above the table size the limit caps at the number of entries
      write_max_links(3'd7);
      for (int id = 1; id <= 4; id++)
         send_beat(make_beat(OP_ENSLAVE, 4'(id), 32'(id * 1000), '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd6, 32'd64, '0, ALL_UP));
      drain_results();
      write_max_links(3'd1);
      send_beat(make_beat(OP_ENSLAVE, 4'd8, 32'd64, '0, ALL_UP));
      drain_results();
   endtask

   task automatic test_queue_growth();
      write_max_links(3'd4);
      while (tbl_count > 0)
         send_beat(make_beat(OP_RELEASE, tbl_link[0], '0, '0, ALL_UP));
      send_beat(make_beat(OP_ENSLAVE, 4'd9, '0, '0, ALL_UP));
      // build a backlog on one link with full-size packets
      repeat (GROW_BEATS)
         send_beat(make_beat(OP_TRANSMIT, '0, '0, '1, 16'h0200));
      send_beat(make_beat(OP_TICK, '0, '0, '0, ALL_UP));
      send_beat(make_beat(OP_SET_RATE, 4'd9, '1, '0, ALL_UP));
      send_beat(make_beat(OP_TICK, '0, '0, '0, ALL_UP));
      send_beat(make_beat(OP_TRANSMIT, '0, '0, '1, ALL_UP));
      drain_results();
   endtask

   task automatic test_random_traffic();
      int unsigned limit_plan [8];
      limit_plan = '{7, 1, 0, 3, 6, 2, 5, 4};
      foreach (limit_plan[p]) begin
         drain_results();
         write_max_links(3'(limit_plan[p]));
         // last phase runs back to back
         idle_enable = (p != 7);
         repeat (RANDOM_BEATS) send_beat(random_beat());
      end
      drain_results();
   endtask

   // ----- response checking -----

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (link_result_q.size() == 0) begin
            $display("%0t ns: response with none expected, got 0x%0h", $time, rsp_data);
            mismatches++;
         end else begin
            want = link_result_q.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_data.status));
            compare_field("selected_link", 32'(want.selected_link),
                          32'(rsp_data.selected_link));
            compare_field("link_rate", want.link_rate, rsp_data.link_rate);
            compare_field("removed_valid", 32'(want.removed_valid),
                          32'(rsp_data.removed_valid));
            compare_field("removed_link", 32'(want.removed_link),
                          32'(rsp_data.removed_link));
            results_checked++;
         end
      end
   end

   // Abort when no beat moves in either direction for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog expired after %0d idle cycles, %0d responses owed",
                     $time, stall_cycles, link_result_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ----- sequence -----

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_table_fill();
      test_selection();
      test_rate_update();
      test_table_limits();
      test_queue_growth();
      test_random_traffic();
      $display("Checked %0d responses from %0d beats: %0d sent, %0d dropped, %0d removed, %0d full",
               results_checked, beats_sent, packets_sent, packets_dropped, links_removed,
               full_rejects);
      $display("Covered max_links 0 to 7, tie-breaking and queued-count growth");
      if (mismatches == 0 && link_result_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
